// ===== rtl/core/plen_pkg.sv =====
package plen_pkg;

   // default coordinate width
   localparam int unsigned COORD_BITS_DEF = 7;

   // width of the emitted total and its saturation ceiling
   localparam int unsigned TOTAL_BITS = 16;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 16'hFFFF;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SQX   = 5'b00010,
      ST_SQY   = 5'b00100,
      ST_ROOT  = 5'b01000,
      ST_ACCUM = 5'b10000
   } state_type;

endpackage

// ===== rtl/core/path_length_accumulator_top.sv =====
// path length accumulator: takes the points of a track one request at a time
// (x, y and a last-point flag) and adds floor(sqrt(dx*dx + dy*dy)) from the
// previous point to a 16-bit total that saturates at 65535. the point flagged
// last produces one response carrying the total, and the block then starts a
// fresh track; a track of one point reports 0. only one request is in flight:
// a point that has a predecessor passes through SQX, SQY, ROOT and ACCUM
// before req_ready returns, while the first point of a track goes through
// ACCUM alone. the square root resolves one result bit per cycle over
// COORD_BITS + 1 steps, after one shared multiplier has formed dx squared
// and then dy squared.
// the response sits in an output register, so the next point may be accepted
// while a finished total still waits for rsp_ready; a last point finishing
// while an earlier total is still unread holds until that total is taken.
module path_length_accumulator_top #(
   parameter int unsigned COORD_BITS = plen_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [COORD_BITS-1:0]           req_x_coord,
   input  logic [COORD_BITS-1:0]           req_y_coord,
   input  logic                            req_last_point,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [plen_pkg::TOTAL_BITS-1:0] rsp_total_length
);

   // radicand is dx^2 + dy^2, padded to an even width for the bit-pair root
   localparam int unsigned ROOT_W  = COORD_BITS + 1;
   localparam int unsigned RAD_W   = 2 * ROOT_W;
   localparam int unsigned PROD_W  = 2 * COORD_BITS;
   localparam int unsigned REM_W   = ROOT_W + 1;
   localparam int unsigned TRIAL_W = REM_W + 2;
   localparam int unsigned CNT_W   = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;
   localparam int unsigned TB      = plen_pkg::TOTAL_BITS;
   localparam int unsigned SUM_W   = ((ROOT_W > TB) ? ROOT_W : TB) + 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);

   plen_pkg::state_type state_ff, state_in;

   // track state
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic [TB-1:0]         total_ff, total_in;
   logic                  have_prev_ff, have_prev_in;

   // per-request working registers
   logic [COORD_BITS-1:0] dx_ff, dx_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic                  last_ff, last_in;
   logic [RAD_W-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TB-1:0]         rsp_total_ff, rsp_total_in;

   // shared datapath signals
   logic                  req_fire;
   logic                  out_free;
   logic [COORD_BITS-1:0] mul_op;
   logic [PROD_W-1:0]     mul_prod;
   logic [TRIAL_W-1:0]    rem_shift;
   logic [TRIAL_W-1:0]    trial;
   logic                  trial_ok;
   logic [TRIAL_W-1:0]    trial_diff;
   logic [SUM_W-1:0]      sum_wide;
   logic [TB-1:0]         sum_sat;

   assign req_ready = (state_ff == plen_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_length = rsp_total_ff;

   // one multiplier squares dx, then dy
   assign mul_op   = (state_ff == plen_pkg::ST_SQX) ? dx_ff : dy_ff;
   assign mul_prod = mul_op * mul_op;

   // restoring root step: bring down the next radicand bit pair
   assign rem_shift  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial      = {1'b0, root_ff, 2'b01};
   assign trial_ok   = (rem_shift >= trial);
   assign trial_diff = rem_shift - trial;

   // saturating add of the segment length
   assign sum_wide = SUM_W'(total_ff) + SUM_W'(root_ff);
   assign sum_sat  = (sum_wide > SUM_W'(plen_pkg::TOTAL_MAX)) ? plen_pkg::TOTAL_MAX
                                                              : sum_wide[TB-1:0];

   always_comb begin
      state_in     = state_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      total_in     = total_ff;
      have_prev_in = have_prev_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      last_in      = last_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         plen_pkg::ST_IDLE: begin
            if (req_fire) begin
               dx_in        = (req_x_coord > prev_x_ff) ? req_x_coord - prev_x_ff
                                                        : prev_x_ff - req_x_coord;
               dy_in        = (req_y_coord > prev_y_ff) ? req_y_coord - prev_y_ff
                                                        : prev_y_ff - req_y_coord;
               last_in      = req_last_point;
               root_in      = '0;
               rem_in       = '0;
               // a new track clears its history after its last point
               prev_x_in    = req_last_point ? '0 : req_x_coord;
               prev_y_in    = req_last_point ? '0 : req_y_coord;
               have_prev_in = !req_last_point;
               // first point of a track has no segment
               state_in     = have_prev_ff ? plen_pkg::ST_SQX : plen_pkg::ST_ACCUM;
            end
         end
         plen_pkg::ST_SQX: begin
            rad_in   = RAD_W'(mul_prod);
            state_in = plen_pkg::ST_SQY;
         end
         plen_pkg::ST_SQY: begin
            rad_in   = rad_ff + RAD_W'(mul_prod);
            cnt_in   = LAST_STEP;
            state_in = plen_pkg::ST_ROOT;
         end
         plen_pkg::ST_ROOT: begin
            rad_in  = rad_ff << 2;
            rem_in  = trial_ok ? trial_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], trial_ok};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = plen_pkg::ST_ACCUM;
            end
         end
         plen_pkg::ST_ACCUM: begin
            if (!last_ff) begin
               total_in = sum_sat;
               state_in = plen_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = sum_sat;
               total_in     = '0;
               state_in     = plen_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plen_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plen_pkg::ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         total_ff     <= '0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         total_ff     <= total_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      last_ff      <= last_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      cnt_ff       <= cnt_in;
      rsp_total_ff <= rsp_total_in;
   end

   // a point with a predecessor goes to the multiplier
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && have_prev_ff) |=> (state_ff == plen_pkg::ST_SQX))
      else $error("segment request skipped the multiplier");

   // a first point goes straight to accumulation with a zero segment
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !have_prev_ff) |=> (state_ff == plen_pkg::ST_ACCUM && root_ff == '0))
      else $error("first point did not bypass the root");

   // a response appears only from accumulation of a last point
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == plen_pkg::ST_ACCUM && $past(last_ff)))
      else $error("response raised outside accumulation");

   // after a last point the track state is clean
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (total_ff == '0 && !have_prev_ff))
      else $error("track state not cleared after last point");

endmodule

// ===== tb/tb.sv =====
module tb;

   localparam int unsigned CW        = plen_pkg::COORD_BITS_DEF;
   localparam int          COORD_TOP = (1 << CW) - 1;
   localparam int          POINT_GOAL = 1950;

   // one track point as offered on the request channel
   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          last;
   } point_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [CW-1:0]                   req_x_coord = '0;
   logic [CW-1:0]                   req_y_coord = '0;
   logic                            req_last_point = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [plen_pkg::TOTAL_BITS-1:0] rsp_total_length;

   // points waiting to be offered, and totals the block still owes us
   point_type                       pending_points[$];
   logic [plen_pkg::TOTAL_BITS-1:0] expected_totals[$];

   int points_accepted = 0;
   int mismatches      = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   // our own copy of the track state
   logic [CW-1:0]                   track_prev_x = '0;
   logic [CW-1:0]                   track_prev_y = '0;
   logic [plen_pkg::TOTAL_BITS-1:0] track_sum    = '0;
   bit                              track_open   = 1'b0;

   path_length_accumulator_top #(.COORD_BITS(CW)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_total_length (rsp_total_length)
   );

   always #5 clock = ~clock;

   // floor square root by trying each result bit from the top down
   function automatic int unsigned root_floor(int unsigned v);
      int unsigned r;
      int unsigned trial;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = r | (32'd1 << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   // fold one accepted point into the track; a last point yields a total
   task automatic track_point(input point_type p);
      int unsigned dx;
      int unsigned dy;
      int unsigned sum;
      if (track_open) begin
         dx  = (p.x > track_prev_x) ? p.x - track_prev_x : track_prev_x - p.x;
         dy  = (p.y > track_prev_y) ? p.y - track_prev_y : track_prev_y - p.y;
         sum = track_sum + root_floor(dx * dx + dy * dy);
         track_sum = (sum > plen_pkg::TOTAL_MAX) ? plen_pkg::TOTAL_MAX
                                                 : sum[plen_pkg::TOTAL_BITS-1:0];
      end
      track_prev_x = p.x;
      track_prev_y = p.y;
      track_open   = 1'b1;
      if (p.last) begin
         expected_totals.push_back(track_sum);
         track_prev_x = '0;
         track_prev_y = '0;
         track_sum    = '0;
         track_open   = 1'b0;
      end
   endtask

   // idle mix: sender light / receiver heavy, then swapped, then none
   function automatic int sender_idle_pct();
      if (points_accepted < 650) return 6;
      if (points_accepted < 1300) return 63;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (points_accepted < 650) return 63;
      if (points_accepted < 1300) return 6;
      return 0;
   endfunction

   // request driver: hold the payload until taken, then maybe pull the next point
   always @(posedge clock) begin : drive_points
      point_type cur;
      point_type nxt;
      logic      offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            cur = '{x: req_x_coord, y: req_y_coord, last: req_last_point};
            track_point(cur);
            points_accepted <= points_accepted + 1;
            offer = 1'b0;
         end
         if (!offer && pending_points.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct()) begin
            nxt = pending_points.pop_front();
            req_x_coord    <= nxt.x;
            req_y_coord    <= nxt.y;
            req_last_point <= nxt.last;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // one long receiver hold-off while points keep coming, to back the block up
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && points_accepted >= 1350) begin
            hold_left <= 300;
            hold_done <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // response ready, random per cycle and forced low during the hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // response monitor: every accepted total against the oldest expectation
   always @(posedge clock) begin : check_totals
      logic [plen_pkg::TOTAL_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_totals.size() == 0) begin
            $error("total_length: expected none, actual %0d", rsp_total_length);
            mismatches++;
         end else begin
            want = expected_totals.pop_front();
            if (rsp_total_length !== want) begin
               $error("total_length: expected %0d, actual %0d", want, rsp_total_length);
               mismatches++;
            end
         end
      end
   end

   int points_queued = 0;

   task automatic queue_point(input int x, input int y, input bit last);
      point_type p;
      p.x    = x[CW-1:0];
      p.y    = y[CW-1:0];
      p.last = last;
      pending_points.push_back(p);
      points_queued++;
   endtask

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_TOP) return COORD_TOP;
      return v;
   endfunction

   initial begin : stimulus
      int  len;
      int  px;
      int  py;
      bit  near;
      bit  sat_done;

      // single-point tracks report zero, at both corners
      queue_point(0, 0, 1);
      queue_point(COORD_TOP, COORD_TOP, 1);
      // full diagonals, both directions
      queue_point(0, 0, 0);
      queue_point(COORD_TOP, COORD_TOP, 1);
      queue_point(COORD_TOP, 0, 0);
      queue_point(0, COORD_TOP, 1);
      // repeated point, zero-length segments
      queue_point(5, 5, 0);
      queue_point(5, 5, 0);
      queue_point(5, 5, 1);
      // exact roots and a pure horizontal run
      queue_point(0, 0, 0);
      queue_point(3, 4, 0);
      queue_point(0, 0, 0);
      queue_point(COORD_TOP, 0, 1);
      // a unit diagonal floors to one, followed by a unit step
      queue_point(100, 99, 0);
      queue_point(99, 100, 0);
      queue_point(99, 99, 1);
      // vertical extreme and a mixed pair
      queue_point(0, COORD_TOP, 0);
      queue_point(0, 0, 0);
      queue_point(64, 1, 0);
      queue_point(1, 64, 1);

      // random tracks, mostly short; one long track drives the sum into saturation
      sat_done = 1'b0;
      while (points_queued < POINT_GOAL) begin
         if (!sat_done && points_queued >= 1500) begin
            for (int i = 0; i < 400; i++) begin
               if (i % 2 == 0) queue_point($urandom_range(2), $urandom_range(2), 0);
               else queue_point(COORD_TOP - $urandom_range(2),
                                COORD_TOP - $urandom_range(2), i == 399);
            end
            sat_done = 1'b1;
         end else begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
            near = $urandom_range(1);
            px   = $urandom_range(COORD_TOP);
            py   = $urandom_range(COORD_TOP);
            for (int i = 0; i < len; i++) begin
               if (i != 0 && near) begin
                  px = clamp_coord(px + $urandom_range(6) - 3);
                  py = clamp_coord(py + $urandom_range(6) - 3);
               end else if (i != 0) begin
                  px = $urandom_range(COORD_TOP);
                  py = $urandom_range(COORD_TOP);
               end
               queue_point(px, py, i == len - 1);
            end
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: every point taken, every total seen, then a short quiet tail
      while (pending_points.size() != 0 || req_valid) @(posedge clock);
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && expected_totals.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/plen_pkg.sv
rtl/core/path_length_accumulator_top.sv
tb/tb.sv
